// ----- hw/rtl/cfd_pkg.sv -----
// cfd_pkg: shared types and constants for the command fifo with duplicate check
// holds the frame layout, operation codes and sequencer states; no dependencies
package cfd_pkg;

    localparam int FRAME_W = 64;

    typedef struct packed {
        logic [7:0]  op;
        logic [31:0] value;
        logic [15:0] request;
        logic [7:0]  seq;
    } t_frame;

    typedef enum logic [1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_RECORD = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POPWAIT,
        S_SCAN,
        S_QDONE,
        S_EMIT
    } t_state;

endpackage

// ----- hw/rtl/cfd_ram.sv -----
// cfd_ram: generic single write port, single read port ram with registered read
// no dependencies
module cfd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/cfd_match.sv -----
// cfd_match: shared frame comparator with a sticky hit flag
// compares one candidate frame a cycle against the key; depends on cfd_pkg
module cfd_match (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_clear,
    input  logic           i_en,
    input  cfd_pkg::t_frame i_key,
    input  cfd_pkg::t_frame i_cand,
    output logic           o_hit
);
    import cfd_pkg::*;

    logic r_hit;
    logic n_hit;

    always_comb begin
        if (i_clear) begin
            n_hit = 1'b0;
        end else begin
            n_hit = r_hit | (i_en && (i_key == i_cand));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    assign o_hit = r_hit;

endmodule

// ----- hw/rtl/command_fifo_with_dedup_unit.sv -----
// command_fifo_with_dedup_unit: ring fifo of command frames with duplicate check
// depends on cfd_pkg, cfd_ram (frame storage) and cfd_match (shared comparator)
//
//  channel   dir  handshake           payload
//  input     in   i_valid / o_stall   i_func, i_cmd_op, i_cmd_value, i_cmd_request, i_cmd_seq
//  result    out  o_valid / i_stall   o_status_ok, o_out_op, o_out_value, o_out_request,
//                                     o_out_seq, o_fill_level
//
// push, record and a failed pop pass from accept through the exec and emit states to the
// output register; a pop also passes the pop-wait state for the registered ram read
// a duplicate query passes the exec, scan, done and emit states, skipping scan when empty;
// the single comparator walks the queued frames one per cycle through the ram read port,
// after checking the last-processed frame
// synchronous active-low reset clears state, pointers, count, last-valid, last frame and
// output valid; slot storage is not cleared, only written entries are ever read
// a stalled result holds the sequencer in its emit state; no new item is
// taken until the current one has been handed to the output register
module command_fifo_with_dedup_unit #(
    parameter int DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_cmd_op,
    input  logic [31:0] i_cmd_value,
    input  logic [15:0] i_cmd_request,
    input  logic [7:0]  i_cmd_seq,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_status_ok,
    output logic [7:0]  o_out_op,
    output logic [31:0] o_out_value,
    output logic [15:0] o_out_request,
    output logic [7:0]  o_out_seq,
    output logic [3:0]  o_fill_level
);
    import cfd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // sequencer and ring state
    t_state             r_state, n_state;
    t_func              r_func, n_func;
    t_frame             r_frame, n_frame;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_last_valid, n_last_valid;
    t_frame             r_last, n_last;
    // query walk
    logic [PTR_W-1:0]   r_scan_ptr, n_scan_ptr;
    logic [CNT_W-1:0]   r_scan_left, n_scan_left;
    // result staging
    logic               r_res_ok, n_res_ok;
    t_frame             r_res_frame, n_res_frame;
    // output register
    logic               r_out_valid, n_out_valid;
    logic               r_out_ok, n_out_ok;
    t_frame             r_out_frame, n_out_frame;
    logic [3:0]         r_out_fill, n_out_fill;

    // ram and comparator hookup
    logic               ram_we;
    logic               ram_re;
    logic [PTR_W-1:0]   ram_raddr;
    logic [FRAME_W-1:0] ram_rdata;
    t_frame             ram_frame;
    logic               match_clear;
    logic               match_en;
    t_frame             match_cand;
    logic               match_hit;

    logic               in_take;
    logic               out_take;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign ram_frame = t_frame'(ram_rdata);
    assign o_stall   = (r_state != S_IDLE);
    assign in_take   = i_valid && (r_state == S_IDLE);
    assign out_take  = r_out_valid && !i_stall;

    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_frame      = r_frame;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_last_valid = r_last_valid;
        n_last       = r_last;
        n_scan_ptr   = r_scan_ptr;
        n_scan_left  = r_scan_left;
        n_res_ok     = r_res_ok;
        n_res_frame  = r_res_frame;
        n_out_valid  = r_out_valid && !out_take;
        n_out_ok     = r_out_ok;
        n_out_frame  = r_out_frame;
        n_out_fill   = r_out_fill;

        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = r_head;
        match_clear = 1'b0;
        match_en    = 1'b0;
        match_cand  = ram_frame;

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_func      = t_func'(i_func);
                    n_frame     = '{op: i_cmd_op, value: i_cmd_value,
                                    request: i_cmd_request, seq: i_cmd_seq};
                    n_res_ok    = 1'b0;
                    n_res_frame = '0;
                    match_clear = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_func)
                    FUNC_PUSH: begin
                        if (r_count < CNT_W'(DEPTH)) begin
                            ram_we   = 1'b1;
                            n_tail   = f_next(r_tail);
                            n_count  = r_count + 1'b1;
                            n_res_ok = 1'b1;
                        end
                        n_state = S_EMIT;
                    end
                    FUNC_POP: begin
                        if (r_count != '0) begin
                            ram_re  = 1'b1;
                            n_state = S_POPWAIT;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end
                    FUNC_QUERY: begin
                        // last-processed frame goes through the comparator first
                        match_cand  = r_last;
                        match_en    = r_last_valid;
                        ram_re      = 1'b1;
                        n_scan_ptr  = r_head;
                        n_scan_left = r_count;
                        n_state     = (r_count != '0) ? S_SCAN : S_QDONE;
                    end
                    FUNC_RECORD: begin
                        n_last_valid = 1'b1;
                        n_last       = r_frame;
                        n_res_ok     = 1'b1;
                        n_state      = S_EMIT;
                    end
                    default: begin
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_POPWAIT: begin
                n_res_frame = ram_frame;
                n_res_ok    = 1'b1;
                n_head      = f_next(r_head);
                n_count     = r_count - 1'b1;
                n_state     = S_EMIT;
            end
            S_SCAN: begin
                // ram data belongs to the slot at r_scan_ptr
                match_en = 1'b1;
                if (r_scan_left == CNT_W'(1)) begin
                    n_state = S_QDONE;
                end else begin
                    ram_re      = 1'b1;
                    ram_raddr   = f_next(r_scan_ptr);
                    n_scan_ptr  = f_next(r_scan_ptr);
                    n_scan_left = r_scan_left - 1'b1;
                end
            end
            S_QDONE: begin
                n_res_ok = match_hit;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || out_take) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_frame = r_res_frame;
                    n_out_fill  = 4'(r_count);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_last_valid <= 1'b0;
            r_last       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_last_valid <= n_last_valid;
            r_last       <= n_last;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_frame     <= n_frame;
        r_scan_ptr  <= n_scan_ptr;
        r_scan_left <= n_scan_left;
        r_res_ok    <= n_res_ok;
        r_res_frame <= n_res_frame;
        r_out_ok    <= n_out_ok;
        r_out_frame <= n_out_frame;
        r_out_fill  <= n_out_fill;
    end

    cfd_ram #(
        .WIDTH(FRAME_W),
        .DEPTH(DEPTH)
    ) u_slots (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_tail),
        .i_wdata(FRAME_W'(r_frame)),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    cfd_match u_match (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_clear(match_clear),
        .i_en   (match_en),
        .i_key  (r_frame),
        .i_cand (match_cand),
        .o_hit  (match_hit)
    );

    assign o_valid       = r_out_valid;
    assign o_status_ok   = r_out_ok;
    assign o_out_op      = r_out_frame.op;
    assign o_out_value   = r_out_frame.value;
    assign o_out_request = r_out_frame.request;
    assign o_out_seq     = r_out_frame.seq;
    assign o_fill_level  = r_out_fill;

endmodule
